>>> hdl/hall_window_activity_detector_assert.svh
// Assertion macros used by the detector core module.
// Each macro checks a property on the rising clock edge, with reset held off.
`ifndef HALL_WINDOW_ACTIVITY_DETECTOR_ASSERT_SVH
`define HALL_WINDOW_ACTIVITY_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define HWAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent holds in the cycle after the antecedent.
`define HWAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define HWAD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HWAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/hwad_pkg.sv
package hwad_pkg;

    // Default parameter values.
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int INTERVAL_BITS_DEF = 16;

    // Register field widths.
    localparam int LEVEL_BITS = 10;
    localparam int LIMIT_BITS = 16;
    localparam int RUN_BITS   = 10;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LOW   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DISCONNECT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_RUN_LEN = 3'd4;

    // Register reset values.
    localparam logic [LEVEL_BITS-1:0] WINDOW_LOW_RST   = 10'd520;
    localparam logic [LEVEL_BITS-1:0] WINDOW_HIGH_RST  = 10'd680;
    localparam logic [LEVEL_BITS-1:0] DISCONNECT_RST   = 10'd1000;
    localparam logic [LIMIT_BITS-1:0] SHORT_LIMIT_RST  = 16'd200;
    localparam logic [RUN_BITS-1:0]   STOP_RUN_LEN_RST = 10'd1000;

    // Item command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [LEVEL_BITS-1:0] window_low;
        logic [LEVEL_BITS-1:0] window_high;
        logic [LEVEL_BITS-1:0] disconnect_level;
        logic [LIMIT_BITS-1:0] short_interval_limit;
        logic [RUN_BITS-1:0]   stop_run_length;
    } cfg_t;

    // Comparator verdict for one sample.
    typedef struct packed {
        logic hit;
        logic disconnect;
    } win_t;

endpackage

>>> hdl/hwad_cfg.sv
module hwad_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hwad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hwad_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output hwad_pkg::cfg_t                       cfg
);
    import hwad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The register file takes a word in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_LOW:   cfg_next.window_low = cfg_data[LEVEL_BITS-1:0];
                REG_WINDOW_HIGH:  cfg_next.window_high = cfg_data[LEVEL_BITS-1:0];
                REG_DISCONNECT:   cfg_next.disconnect_level = cfg_data[LEVEL_BITS-1:0];
                REG_SHORT_LIMIT:  cfg_next.short_interval_limit = cfg_data[LIMIT_BITS-1:0];
                REG_STOP_RUN_LEN: cfg_next.stop_run_length = cfg_data[RUN_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low           <= WINDOW_LOW_RST;
            cfg_reg.window_high          <= WINDOW_HIGH_RST;
            cfg_reg.disconnect_level     <= DISCONNECT_RST;
            cfg_reg.short_interval_limit <= SHORT_LIMIT_RST;
            cfg_reg.stop_run_length      <= STOP_RUN_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/hwad_window.sv
module hwad_window #(
    parameter int SAMPLE_BITS = hwad_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   mode_inside,
    input  hwad_pkg::cfg_t         cfg,
    output hwad_pkg::win_t         verdict
);
    import hwad_pkg::*;

    // Compare at the wider of the sample and level widths.
    localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

    logic [CMP_BITS-1:0] sample_ext;
    logic [CMP_BITS-1:0] low_ext;
    logic [CMP_BITS-1:0] high_ext;
    logic [CMP_BITS-1:0] disc_ext;

    assign sample_ext = CMP_BITS'(sample);
    assign low_ext    = CMP_BITS'(cfg.window_low);
    assign high_ext   = CMP_BITS'(cfg.window_high);
    assign disc_ext   = CMP_BITS'(cfg.disconnect_level);

    // Outside mode hits beyond the bounds; inside mode hits strictly between them.
    always_comb
    begin
        if (mode_inside)
        begin
            verdict.hit = (sample_ext > low_ext) && (sample_ext < high_ext);
        end
        else
        begin
            verdict.hit = (sample_ext < low_ext) || (sample_ext > high_ext);
        end
        verdict.disconnect = (sample_ext >= disc_ext);
    end

endmodule

>>> hdl/hwad_core.sv
module hwad_core #(
    parameter int INTERVAL_BITS = hwad_pkg::INTERVAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          item_command,
    input  hwad_pkg::win_t                verdict,
    input  hwad_pkg::cfg_t                cfg,
    input  logic                          out_ready,
    output logic                          mode_state,
    output logic                          out_valid,
    output logic                          comparator_hit,
    output logic                          timer_active,
    output logic                          sensor_connected,
    output logic                          sensor_disconnected,
    output logic                          window_mode,
    output logic                          clear_main_count,
    output logic [hwad_pkg::RUN_BITS-1:0] short_run_count
);
    import hwad_pkg::*;

    `include "hall_window_activity_detector_assert.svh"

    localparam int LIM_BITS = (INTERVAL_BITS > LIMIT_BITS) ? INTERVAL_BITS : LIMIT_BITS;

    // Detector state.
    logic                     mode_reg, mode_next;
    logic                     conn_reg, conn_next;
    logic                     disc_reg, disc_next;
    logic                     active_reg, active_next;
    logic                     running_reg, running_next;
    logic [INTERVAL_BITS-1:0] count_reg, count_next;
    logic [RUN_BITS-1:0]      run_reg, run_next;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg, hit_next;
    logic                     clear_reg, clear_next;

    logic [RUN_BITS-1:0]      run_inc;
    logic                     interval_long;
    logic                     count_full;

    assign run_inc       = run_reg + RUN_BITS'(1);
    assign interval_long = LIM_BITS'(count_reg) > LIM_BITS'(cfg.short_interval_limit);
    assign count_full    = &count_reg;

    // State update for the word moving into the result register.
    always_comb
    begin
        mode_next    = mode_reg;
        conn_next    = conn_reg;
        disc_next    = disc_reg;
        active_next  = active_reg;
        running_next = running_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        hit_next     = hit_reg;
        clear_next   = clear_reg;
        if (advance)
        begin
            hit_next   = 1'b0;
            clear_next = 1'b0;
            case (item_command)
                CMD_TICK:
                begin
                    if (running_reg && !count_full)
                    begin
                        count_next = count_reg + INTERVAL_BITS'(1);
                    end
                end
                CMD_SAMPLE:
                begin
                    hit_next = verdict.hit;
                    if (verdict.hit && !mode_reg)
                    begin
                        if (verdict.disconnect)
                        begin
                            conn_next = 1'b0;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            disc_next   = 1'b0;
                            active_next = 1'b1;
                        end
                        mode_next = 1'b1;
                    end
                    else if (verdict.hit)
                    begin
                        if (!conn_reg)
                        begin
                            conn_next = 1'b1;
                            mode_next = 1'b0;
                        end
                        else if (!running_reg)
                        begin
                            running_next = 1'b1;
                        end
                        else
                        begin
                            // Read the interval and judge it.
                            count_next = '0;
                            if (interval_long)
                            begin
                                run_next = '0;
                            end
                            else if (run_inc >= cfg.stop_run_length)
                            begin
                                active_next  = 1'b0;
                                run_next     = '0;
                                mode_next    = 1'b0;
                                running_next = 1'b0;
                                clear_next   = 1'b1;
                            end
                            else
                            begin
                                run_next = run_inc;
                            end
                        end
                    end
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    // The result register fills on advance and empties when taken.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            conn_reg      <= 1'b0;
            disc_reg      <= 1'b0;
            active_reg    <= 1'b0;
            running_reg   <= 1'b0;
            count_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            clear_reg     <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            conn_reg      <= conn_next;
            disc_reg      <= disc_next;
            active_reg    <= active_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            clear_reg     <= clear_next;
        end
    end

    // The status fields show the state left by the last word.
    assign mode_state          = mode_reg;
    assign out_valid           = out_valid_reg;
    assign comparator_hit      = hit_reg;
    assign timer_active        = active_reg;
    assign sensor_connected    = conn_reg;
    assign sensor_disconnected = disc_reg;
    assign window_mode         = mode_reg;
    assign clear_main_count    = clear_reg;
    assign short_run_count     = run_reg;

    // A stop pulse comes with the timer halted, outside mode and an empty run.
    `HWAD_ASSERT_SAME(a_clear_stops, clk, rst_n, out_valid_reg && clear_reg, !active_reg && !mode_reg && !running_reg && (run_reg == '0))

    // A stop pulse is only raised by a comparator hit.
    `HWAD_ASSERT_SAME(a_clear_needs_hit, clk, rst_n, out_valid_reg && clear_reg, hit_reg)

    // Without a word moving through, the state holds.
    `HWAD_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(count_reg) && $stable(run_reg) && $stable(mode_reg))

endmodule

>>> hdl/hall_window_activity_detector.sv
// A word in the input register has its result registered once the result register
// is free or being emptied. Throughput: one word per cycle while out_ready holds;
// a word enters while the previous result waits. The state update is combinational.
// Reset (rst_n, asynchronous, active low): registers return to their defaults,
// all detector flags and counters clear, and both staging registers empty.
module hall_window_activity_detector #(
    parameter int SAMPLE_BITS   = hwad_pkg::SAMPLE_BITS_DEF,
    parameter int INTERVAL_BITS = hwad_pkg::INTERVAL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hwad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hwad_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [SAMPLE_BITS-1:0]              adc_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                comparator_hit,
    output logic                                timer_active,
    output logic                                sensor_connected,
    output logic                                sensor_disconnected,
    output logic                                window_mode,
    output logic                                clear_main_count,
    output logic [hwad_pkg::RUN_BITS-1:0]       short_run_count
);
    import hwad_pkg::*;

    cfg_t                   cfg;
    win_t                   verdict;
    logic                   mode_state;
    logic                   advance;

    logic                   item_valid_reg, item_valid_next;
    logic                   item_command_reg;
    logic [SAMPLE_BITS-1:0] item_sample_reg;

    // The held word moves on when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // Input register.
    always_comb
    begin
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_command_reg <= command;
            item_sample_reg  <= adc_value;
        end
    end

    // Configuration registers.
    hwad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window comparator on the held sample.
    hwad_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .sample      (item_sample_reg),
        .mode_inside (mode_state),
        .cfg         (cfg),
        .verdict     (verdict)
    );

    // State update and result register.
    hwad_core #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .advance             (advance),
        .item_command        (item_command_reg),
        .verdict             (verdict),
        .cfg                 (cfg),
        .out_ready           (out_ready),
        .mode_state          (mode_state),
        .out_valid           (out_valid),
        .comparator_hit      (comparator_hit),
        .timer_active        (timer_active),
        .sensor_connected    (sensor_connected),
        .sensor_disconnected (sensor_disconnected),
        .window_mode         (window_mode),
        .clear_main_count    (clear_main_count),
        .short_run_count     (short_run_count)
    );

endmodule
